// ===== design/gaussian_diag_neg2_loglike_macros.svh =====
// Assertion macros shared by the gaussian_diag_neg2_loglike block
`ifndef GAUSSIAN_DIAG_NEG2_LOGLIKE_MACROS_SVH
`define GAUSSIAN_DIAG_NEG2_LOGLIKE_MACROS_SVH
`ifndef ASSERT_OFF
`define GDNL_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("gdnl: implication check failed");
`define GDNL_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("gdnl: next-cycle check failed");
`else
`define GDNL_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define GDNL_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

// ===== design/gdnl_pkg.sv =====
// Shared types, constants and helpers of the Gaussian -2 ln L block
package gdnl_pkg;

   localparam int FRAC_BITS_DEFAULT = 16;
   // power of two: queue pointers wrap naturally
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH = 16;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_WEIGHTED_MEAN_MODE = 8'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_POINT_COUNT = 8'd1;

   localparam logic [63:0] LN2_Q64 = 64'hB17217F7D1CF79AC;
   localparam logic [32:0] LN2PI_Q32 = 33'd7893621894;
   localparam logic signed [63:0] SUM_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [63:0] SUM_MIN = 64'sh8000_0000_0000_0000;

   typedef struct packed {
      logic signed [31:0] observed;
      logic signed [31:0] model_value;
      logic [30:0]        std_dev;
      logic               last_point;
   } req_payload_type;

   typedef struct packed {
      logic signed [63:0] neg_two_log_like;
      logic               error_flag;
   } rsp_payload_type;

   // one classified point handed from front to back
   typedef struct packed {
      logic [63:0]        chi_term;
      logic signed [63:0] log_term;
      logic [63:0]        weight;
      logic signed [63:0] res_weight;
      logic               zero_dev;
      logic               div_err;
      logic               last;
   } entry_type;

   typedef struct packed {
      logic                 full;
      logic                 empty;
      logic [QUEUE_PTR_W:0] count;
   } queue_status_type;

   typedef struct packed {
      logic signed [63:0] sum;
      logic               ovf;
   } sat_result_type;

   typedef enum logic [2:0] {
      F_IDLE, F_SQ_S, F_SQ_R, F_DIV_GO, F_DIV_WAIT, F_WAIT_LOG, F_PUSH
   } front_state_type;

   typedef enum logic [1:0] {JOB_Q, JOB_W, JOB_RW} div_job_type;

   typedef enum logic [2:0] {
      LG_IDLE, LG_NORM, LG_SQ, LG_MAG, LG_MUL, LG_WAIT
   } log_state_type;

   typedef enum logic [3:0] {
      B_IDLE, B_ADD_Q, B_ADD_LN, B_CHECK, B_CMUL, B_CMUL_WAIT,
      B_CDIV, B_CDIV_WAIT, B_ADD_C, B_ADD_N, B_EMIT
   } back_state_type;

   function automatic sat_result_type sat_add(input logic signed [63:0] a,
                                              input logic signed [63:0] b);
      logic signed [64:0] wide;
      sat_result_type     res;
      wide = {a[63], a} + {b[63], b};
      res.ovf = wide[64] ^ wide[63];
      if (res.ovf) begin
         res.sum = b[63] ? SUM_MIN : SUM_MAX;
      end else begin
         res.sum = wide[63:0];
      end
      return res;
   endfunction

endpackage

// ===== design/gdnl_if.sv =====
// Valid/ready channel carrying one payload per beat
interface gdnl_if #(parameter type payload_type = logic) ();
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== design/gdnl_div.sv =====
// Restoring 128/64 divider, one quotient bit per cycle, saturating at 2^63-1
module gdnl_div (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [127:0] dividend,
   input  logic [63:0]  divisor,
   output logic         done,
   output logic [63:0]  quotient,
   output logic         overflow
);
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic [127:0] num_ff, num_in;
   logic [63:0]  den_ff, den_in, rem_ff, rem_in;
   logic [62:0]  quo_ff, quo_in;
   logic         ovf_ff, ovf_in;
   logic [64:0]  trial;
   logic         ge;

   always_comb begin
      trial = {rem_ff, num_ff[127]};
      ge = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      num_in = num_ff;
      den_in = den_ff;
      rem_in = rem_ff;
      quo_in = quo_ff;
      ovf_in = ovf_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         num_in = dividend;
         den_in = divisor;
         rem_in = '0;
         quo_in = '0;
         ovf_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = ge ? 64'(trial - {1'b0, den_ff}) : trial[63:0];
         quo_in = {quo_ff[61:0], ge};
         num_in = {num_ff[126:0], 1'b0};
         // quotient bits 127 down to 63 must stay clear
         if (ge && cnt_ff <= 7'd64) begin
            ovf_in = 1'b1;
         end
         cnt_in = cnt_ff + 7'd1;
         if (cnt_ff == 7'd127) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      ovf_ff <= ovf_in;
   end

   assign done = done_ff;
   assign overflow = ovf_ff;
   assign quotient = ovf_ff ? 64'h7FFF_FFFF_FFFF_FFFF : {1'b0, quo_ff};
endmodule

// ===== design/gdnl_mul.sv =====
// 64x64 multiplier built from four 32x32 partial products summed in turn
module gdnl_mul (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   input  logic [63:0]  a,
   input  logic [63:0]  b,
   output logic         done,
   output logic [127:0] product
);
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic [127:0] acc_ff, acc_in;
   logic [31:0]  a_half, b_half;
   logic [63:0]  pp;
   logic [6:0]   shift;

   always_comb begin
      a_half = cnt_ff[0] ? a_ff[63:32] : a_ff[31:0];
      b_half = cnt_ff[1] ? b_ff[63:32] : b_ff[31:0];
      pp = a_half * b_half;
      shift = 7'({1'b0, cnt_ff[0]} + {1'b0, cnt_ff[1]}) << 5;
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      a_in = a_ff;
      b_in = b_ff;
      acc_in = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         a_in = a;
         b_in = b;
         acc_in = '0;
      end else if (busy_ff) begin
         acc_in = acc_ff + (128'(pp) << shift);
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      a_ff <= a_in;
      b_ff <= b_in;
      acc_ff <= acc_in;
   end

   assign done = done_ff;
   assign product = acc_ff;
endmodule

// ===== design/gdnl_log.sv =====
// 2*ln(sigma) in Q32.32: normalise, log2 by repeated squaring, scale by ln 2
module gdnl_log #(
   parameter int FRAC_BITS = gdnl_pkg::FRAC_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [30:0]        std_dev,
   output logic               done,
   output logic signed [63:0] result
);
   localparam logic [36:0] BASE = 37'(FRAC_BITS) << 32;

   gdnl_pkg::log_state_type state_ff, state_in;
   logic [31:0]        x_ff, frac_ff;
   logic [4:0]         p_ff, k_ff;
   logic [36:0]        mag_ff, lg, mag_in;
   logic               pos_ff, pos_in, done_ff;
   logic signed [63:0] result_ff;
   logic [63:0]        sq;
   logic [31:0]        nx;
   logic               mul_start, mul_done;
   logic [127:0]       mul_prod;
   logic [63:0]        twice_hi;

   gdnl_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       ({27'b0, mag_ff}),
      .b       (gdnl_pkg::LN2_Q64),
      .done    (mul_done),
      .product (mul_prod)
   );

   always_comb begin
      sq = x_ff * x_ff;
      nx = sq[61:30];
      lg = {p_ff, frac_ff};
      pos_in = lg >= BASE;
      mag_in = pos_in ? lg - BASE : BASE - lg;
      twice_hi = {mul_prod[126:64], 1'b0};
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdnl_pkg::LG_IDLE: if (start) state_in = gdnl_pkg::LG_NORM;
         gdnl_pkg::LG_NORM: if (x_ff[30]) state_in = gdnl_pkg::LG_SQ;
         gdnl_pkg::LG_SQ:   if (k_ff == 5'd31) state_in = gdnl_pkg::LG_MAG;
         gdnl_pkg::LG_MAG:  state_in = gdnl_pkg::LG_MUL;
         gdnl_pkg::LG_MUL:  state_in = gdnl_pkg::LG_WAIT;
         gdnl_pkg::LG_WAIT: if (mul_done) state_in = gdnl_pkg::LG_IDLE;
         default:           state_in = gdnl_pkg::LG_IDLE;
      endcase
   end

   always_comb begin
      mul_start = state_ff == gdnl_pkg::LG_MUL;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdnl_pkg::LG_IDLE;
         done_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff <= (state_ff == gdnl_pkg::LG_WAIT) && mul_done;
      end
      unique case (state_ff)
         gdnl_pkg::LG_IDLE: begin
            x_ff <= {1'b0, std_dev};
            p_ff <= 5'd30;
            k_ff <= '0;
            frac_ff <= '0;
         end
         gdnl_pkg::LG_NORM: begin
            if (!x_ff[30]) begin
               x_ff <= {x_ff[30:0], 1'b0};
               p_ff <= p_ff - 5'd1;
            end
         end
         gdnl_pkg::LG_SQ: begin
            x_ff <= nx[31] ? {1'b0, nx[31:1]} : nx;
            frac_ff <= {frac_ff[30:0], nx[31]};
            k_ff <= k_ff + 5'd1;
         end
         gdnl_pkg::LG_MAG: begin
            mag_ff <= mag_in;
            pos_ff <= pos_in;
         end
         gdnl_pkg::LG_MUL: ;
         gdnl_pkg::LG_WAIT: begin
            if (mul_done) begin
               result_ff <= pos_ff ? $signed(twice_hi) : -$signed(twice_hi);
            end
         end
         default: ;
      endcase
   end

   assign done = done_ff;
   assign result = result_ff;
endmodule

// ===== design/gdnl_front.sv =====
// Front end: takes a point, forms r^2*w and 2 ln sigma (w and r*w too in weighted-mean mode), queues the lot
module gdnl_front #(
   parameter int FRAC_BITS = gdnl_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                weighted_mean_mode,
   gdnl_if.sink                req,
   input  logic                queue_full,
   output logic                push,
   output gdnl_pkg::entry_type push_entry
);
   localparam int W_SHIFT = 32 + 2 * FRAC_BITS;
   localparam int RW_SHIFT = 32 + FRAC_BITS;

   gdnl_pkg::front_state_type state_ff, state_in;
   gdnl_pkg::div_job_type     job_ff;
   gdnl_pkg::entry_type       entry_ff;
   logic               r_neg_ff, log_ok_ff;
   logic [31:0]        ra_ff, ra_in;
   logic [30:0]        s_ff;
   logic [61:0]        s2_ff;
   logic [63:0]        r2_ff;
   logic signed [32:0] diff;
   logic               accept, div_start, div_done, div_ovf, log_start, log_done;
   logic [127:0]       div_dividend;
   logic [63:0]        div_quot;
   logic signed [63:0] log_result;

   gdnl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  ({2'b0, s2_ff}),
      .done     (div_done),
      .quotient (div_quot),
      .overflow (div_ovf)
   );

   gdnl_log #(.FRAC_BITS(FRAC_BITS)) u_log (
      .clock   (clock),
      .reset   (reset),
      .start   (log_start),
      .std_dev (s_ff),
      .done    (log_done),
      .result  (log_result)
   );

   always_comb begin
      diff = 33'(req.payload.model_value) - 33'(req.payload.observed);
      ra_in = diff[32] ? 32'(-diff) : diff[31:0];
      unique case (job_ff)
         gdnl_pkg::JOB_Q:  div_dividend = {32'b0, r2_ff, 32'b0};
         gdnl_pkg::JOB_W:  div_dividend = 128'(1) << W_SHIFT;
         gdnl_pkg::JOB_RW: div_dividend = 128'(ra_ff) << RW_SHIFT;
         default:          div_dividend = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdnl_pkg::F_IDLE: begin
            if (req.valid) begin
               state_in = (req.payload.std_dev == '0) ? gdnl_pkg::F_PUSH : gdnl_pkg::F_SQ_S;
            end
         end
         gdnl_pkg::F_SQ_S:   state_in = gdnl_pkg::F_SQ_R;
         gdnl_pkg::F_SQ_R:   state_in = gdnl_pkg::F_DIV_GO;
         gdnl_pkg::F_DIV_GO: state_in = gdnl_pkg::F_DIV_WAIT;
         gdnl_pkg::F_DIV_WAIT: begin
            if (div_done) begin
               if (job_ff == gdnl_pkg::JOB_RW || !weighted_mean_mode) begin
                  state_in = gdnl_pkg::F_WAIT_LOG;
               end else begin
                  state_in = gdnl_pkg::F_DIV_GO;
               end
            end
         end
         gdnl_pkg::F_WAIT_LOG: if (log_ok_ff) state_in = gdnl_pkg::F_PUSH;
         gdnl_pkg::F_PUSH:     if (!queue_full) state_in = gdnl_pkg::F_IDLE;
         default:              state_in = gdnl_pkg::F_IDLE;
      endcase
   end

   always_comb begin
      req.ready = state_ff == gdnl_pkg::F_IDLE;
      accept = req.valid && req.ready;
      log_start = state_ff == gdnl_pkg::F_SQ_S;
      div_start = state_ff == gdnl_pkg::F_DIV_GO;
      push = (state_ff == gdnl_pkg::F_PUSH) && !queue_full;
      push_entry = entry_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdnl_pkg::F_IDLE;
         log_ok_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            log_ok_ff <= 1'b0;
         end else if (log_done) begin
            log_ok_ff <= 1'b1;
         end
      end
      if (accept) begin
         r_neg_ff <= diff[32];
         ra_ff <= ra_in;
         s_ff <= req.payload.std_dev;
         entry_ff <= '{zero_dev: req.payload.std_dev == '0,
                       last: req.payload.last_point,
                       default: '0};
      end
      if (log_done) begin
         entry_ff.log_term <= log_result;
      end
      if (state_ff == gdnl_pkg::F_SQ_S) begin
         s2_ff <= s_ff * s_ff;
      end
      if (state_ff == gdnl_pkg::F_SQ_R) begin
         r2_ff <= ra_ff * ra_ff;
         job_ff <= gdnl_pkg::JOB_Q;
      end
      if (state_ff == gdnl_pkg::F_DIV_WAIT && div_done) begin
         if (div_ovf) begin
            entry_ff.div_err <= 1'b1;
         end
         unique case (job_ff)
            gdnl_pkg::JOB_Q: begin
               entry_ff.chi_term <= div_quot;
               job_ff <= gdnl_pkg::JOB_W;
            end
            gdnl_pkg::JOB_W: begin
               entry_ff.weight <= div_quot;
               job_ff <= gdnl_pkg::JOB_RW;
            end
            gdnl_pkg::JOB_RW: begin
               entry_ff.res_weight <= r_neg_ff ? -$signed(div_quot) : $signed(div_quot);
            end
            default: ;
         endcase
      end
   end
endmodule

// ===== design/gdnl_fifo.sv =====
// Short queue of classified points between front and back
module gdnl_fifo (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  gdnl_pkg::entry_type        push_entry,
   input  logic                       pop,
   output gdnl_pkg::entry_type        head,
   output gdnl_pkg::queue_status_type status
);
   localparam int PW = gdnl_pkg::QUEUE_PTR_W;

   gdnl_pkg::entry_type mem_ff [gdnl_pkg::QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) count_ff <= count_ff + 1'b1;
         else if (pop && !push) count_ff <= count_ff - 1'b1;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head = mem_ff[rd_ptr_ff];
   assign status.count = count_ff;
   assign status.empty = count_ff == '0;
   assign status.full = count_ff == (PW + 1)'(gdnl_pkg::QUEUE_DEPTH);
endmodule

// ===== design/gdnl_back.sv =====
// Back end: saturating sums, weighted-mean correction, normalisation, result register
module gdnl_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                weighted_mean_mode,
   input  logic [15:0]         point_count,
   input  logic                queue_empty,
   input  gdnl_pkg::entry_type head,
   output logic                pop,
   gdnl_if.source              rsp
);
   gdnl_pkg::back_state_type state_ff, state_in;
   gdnl_pkg::entry_type       ent_ff;
   gdnl_pkg::sat_result_type  sat_t, sat_r, sat_w;
   gdnl_pkg::rsp_payload_type rsp_data_ff;
   logic signed [63:0] total_ff, wrs_ff, ws_ff, addend;
   logic               err_ff, rsp_valid_ff, slot_free;
   logic [63:0]        wrs_mag;
   logic [48:0]        norm;
   logic               mul_start, mul_done, div_start, div_done, div_ovf;
   logic [127:0]       mul_prod;
   logic [63:0]        corr;

   gdnl_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (wrs_mag),
      .b       (wrs_mag),
      .done    (mul_done),
      .product (mul_prod)
   );

   gdnl_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (mul_prod),
      .divisor  (ws_ff),
      .done     (div_done),
      .quotient (corr),
      .overflow (div_ovf)
   );

   always_comb begin
      wrs_mag = wrs_ff[63] ? 64'(-wrs_ff) : wrs_ff;
      norm = point_count * gdnl_pkg::LN2PI_Q32;
      unique case (state_ff)
         gdnl_pkg::B_ADD_Q:  addend = $signed(ent_ff.chi_term);
         gdnl_pkg::B_ADD_LN: addend = ent_ff.log_term;
         gdnl_pkg::B_ADD_C:  addend = -$signed(corr);
         default:            addend = $signed(64'(norm));
      endcase
      sat_t = gdnl_pkg::sat_add(total_ff, addend);
      sat_r = gdnl_pkg::sat_add(wrs_ff, ent_ff.res_weight);
      sat_w = gdnl_pkg::sat_add(ws_ff, $signed(ent_ff.weight));
      slot_free = !rsp_valid_ff || rsp.ready;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gdnl_pkg::B_IDLE:   if (!queue_empty) state_in = gdnl_pkg::B_ADD_Q;
         gdnl_pkg::B_ADD_Q:  state_in = ent_ff.zero_dev ? gdnl_pkg::B_CHECK : gdnl_pkg::B_ADD_LN;
         gdnl_pkg::B_ADD_LN: state_in = gdnl_pkg::B_CHECK;
         gdnl_pkg::B_CHECK: begin
            if (!ent_ff.last) begin
               state_in = gdnl_pkg::B_IDLE;
            end else if (weighted_mean_mode && ws_ff > 0) begin
               state_in = gdnl_pkg::B_CMUL;
            end else begin
               state_in = gdnl_pkg::B_ADD_N;
            end
         end
         gdnl_pkg::B_CMUL:      state_in = gdnl_pkg::B_CMUL_WAIT;
         gdnl_pkg::B_CMUL_WAIT: if (mul_done) state_in = gdnl_pkg::B_CDIV;
         gdnl_pkg::B_CDIV:      state_in = gdnl_pkg::B_CDIV_WAIT;
         gdnl_pkg::B_CDIV_WAIT: if (div_done) state_in = gdnl_pkg::B_ADD_C;
         gdnl_pkg::B_ADD_C:     state_in = gdnl_pkg::B_ADD_N;
         gdnl_pkg::B_ADD_N:     state_in = gdnl_pkg::B_EMIT;
         gdnl_pkg::B_EMIT:      if (slot_free) state_in = gdnl_pkg::B_IDLE;
         default:               state_in = gdnl_pkg::B_IDLE;
      endcase
   end

   always_comb begin
      pop = (state_ff == gdnl_pkg::B_IDLE) && !queue_empty;
      mul_start = state_ff == gdnl_pkg::B_CMUL;
      div_start = state_ff == gdnl_pkg::B_CDIV;
      rsp.valid = rsp_valid_ff;
      rsp.payload = rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gdnl_pkg::B_IDLE;
         rsp_valid_ff <= 1'b0;
         total_ff <= '0;
         wrs_ff <= '0;
         ws_ff <= '0;
         err_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == gdnl_pkg::B_EMIT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            gdnl_pkg::B_ADD_Q: begin
               if (ent_ff.zero_dev || ent_ff.div_err || sat_t.ovf) begin
                  err_ff <= 1'b1;
               end
               if (!ent_ff.zero_dev) begin
                  total_ff <= sat_t.sum;
               end
            end
            gdnl_pkg::B_ADD_LN: begin
               total_ff <= sat_t.sum;
               if (sat_t.ovf || (weighted_mean_mode && (sat_r.ovf || sat_w.ovf))) begin
                  err_ff <= 1'b1;
               end
               if (weighted_mean_mode) begin
                  wrs_ff <= sat_r.sum;
                  ws_ff <= sat_w.sum;
               end
            end
            gdnl_pkg::B_ADD_C, gdnl_pkg::B_ADD_N: begin
               total_ff <= sat_t.sum;
               if (sat_t.ovf || (state_ff == gdnl_pkg::B_ADD_C && div_ovf)) begin
                  err_ff <= 1'b1;
               end
            end
            gdnl_pkg::B_EMIT: begin
               if (slot_free) begin
                  total_ff <= '0;
                  wrs_ff <= '0;
                  ws_ff <= '0;
                  err_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
      if (pop) begin
         ent_ff <= head;
      end
      if (state_ff == gdnl_pkg::B_EMIT && slot_free) begin
         rsp_data_ff.neg_two_log_like <= total_ff;
         rsp_data_ff.error_flag <= err_ff;
      end
   end
endmodule

// ===== design/gaussian_diag_neg2_loglike.sv =====
// Top level: -2 ln L of a diagonal Gaussian data set, streamed point by point
//
//  channel | dir | beat contents
//  --------+-----+-----------------------------------------------------------
//  req     | in  | observed, model_value, std_dev, last_point (one point)
//  rsp     | out | neg_two_log_like, error_flag (one per data set)
//  csr     | in  | write enable, register index, data (mode, point count)
//
// Timing: the front divider (one quotient bit a cycle, one quotient per point
//   in plain mode and three in weighted-mean mode) sets the pace; the front
//   takes no new point until the previous one is queued. In weighted-mean mode
//   a last point adds a 64x64 product plus another quotient in the back end.
// Reset: synchronous, clears control state, the sums and the CSR settings.
// Stalls: a 4-beat queue parts front and back; the result waits in an
//   output register while the back end goes on draining the queue.
`include "gaussian_diag_neg2_loglike_macros.svh"

module gaussian_diag_neg2_loglike #(
   parameter int FRAC_BITS = gdnl_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   gdnl_if.sink                                  req,
   gdnl_if.source                                rsp,
   input  logic                                  csr_write_enable,
   input  logic [gdnl_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [gdnl_pkg::CSR_DATA_WIDTH-1:0]   csr_write_data
);
   logic        mode_ff;
   logic [15:0] count_ff;

   // classified points in flight between the two halves
   logic                       q_push, q_pop;
   gdnl_pkg::entry_type        q_in, q_head;
   gdnl_pkg::queue_status_type q_stat;

   // register file: two write-only settings, other indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b0;
         count_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == gdnl_pkg::CSR_WEIGHTED_MEAN_MODE) begin
            mode_ff <= csr_write_data[0];
         end else if (csr_index == gdnl_pkg::CSR_POINT_COUNT) begin
            count_ff <= csr_write_data;
         end
      end
   end

   // front: per-point reciprocal, log and products
   gdnl_front #(.FRAC_BITS(FRAC_BITS)) u_front (
      .clock              (clock),
      .reset              (reset),
      .weighted_mean_mode (mode_ff),
      .req                (req),
      .queue_full         (q_stat.full),
      .push               (q_push),
      .push_entry         (q_in)
   );

   gdnl_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_entry (q_in),
      .pop        (q_pop),
      .head       (q_head),
      .status     (q_stat)
   );

   // back: only additions carry from point to point
   gdnl_back u_back (
      .clock              (clock),
      .reset              (reset),
      .weighted_mean_mode (mode_ff),
      .point_count        (count_ff),
      .queue_empty        (q_stat.empty),
      .head               (q_head),
      .pop                (q_pop),
      .rsp                (rsp)
   );

   `GDNL_ASSERT_IMPLY(a_push_has_room, clock, reset, q_push, !q_stat.full)
   `GDNL_ASSERT_IMPLY(a_pop_has_data, clock, reset, q_pop, !q_stat.empty)
   `GDNL_ASSERT_NEXT(a_lone_push_grows, clock, reset, q_push && !q_pop, !q_stat.empty)
endmodule
